// ===== rtl/lrupr_pkg.sv =====
// lrupr_pkg: shared types and constants of the lru page replacement block
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

    // fixed field widths of the stream and configuration ports
    localparam int PAGE_ID_W    = 16;
    localparam int FRAME_IDX_W  = 3;
    localparam int EVICT_PAGE_W = 16;
    localparam int FAULT_W      = 32;
    localparam int CFG_W        = 4;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 56;

    // frames_in_use value after reset
    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;

    // controller states
    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_page;
        logic execute;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/lrupr_ctrl.sv =====
// lrupr_ctrl: request handshake state machine of the lru page replacement block
// depends on lrupr_pkg; drives commands into lrupr_datapath
`timescale 1ns / 1ps
`default_nettype none

module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        // result taken downstream
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load_page = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                // lookup and update once the result register is free
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;

    // a request is taken only while no lookup is pending
    a_no_accept_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !s_axis_tready)
        else $error("request accepted during lookup");

    // a result that is not taken stays valid
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("pending result dropped");

    // execute never overwrites a pending result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> (!r_out_valid || m_axis_tready))
        else $error("result overwritten");

endmodule

`default_nettype wire

// ===== rtl/lrupr_datapath.sv =====
// lrupr_datapath: frame tags, recency ranks, fill and fault counters, result register
// depends on lrupr_pkg; commanded by lrupr_ctrl
`timescale 1ns / 1ps
`default_nettype none

module lrupr_datapath
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    input  wire logic [PAGE_ID_W-1:0]   i_page_id,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    output logic      [OUT_TDATA_W-1:0] o_tdata
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] r_frame_page [FRAMES];
    logic [PAGE_BITS-1:0] n_frame_page [FRAMES];
    logic [IW-1:0]        r_rank       [FRAMES];
    logic [IW-1:0]        n_rank       [FRAMES];
    logic [CW-1:0]        r_filled, n_filled;
    logic [FAULT_W-1:0]   r_fault, n_fault;
    logic [CFG_W-1:0]     r_frames_in_use;

    logic                    r_out_hit;
    logic [FRAME_IDX_W-1:0]  r_out_frame;
    logic                    r_out_ev;
    logic [EVICT_PAGE_W-1:0] r_out_evp;

    logic [63:0]          w_in64;
    logic [63:0]          w_ev64;
    logic [7:0]           w_f8;
    logic [7:0]           w_lim8;
    logic                 w_hit;
    logic                 w_fill;
    logic [IW-1:0]        w_hit_f;
    logic [IW-1:0]        w_vic_f;
    logic [IW-1:0]        w_f;
    logic [CW-1:0]        w_old;

    // requested page, masked to the page width
    assign w_in64 = 64'(i_page_id);
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_page) begin
            r_page <= w_in64[PAGE_BITS-1:0];
        end
    end

    // frames_in_use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_FRAMES_RESET;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
        end
    end

    // parallel tag compare and lru victim search over filled frames
    always_comb begin
        w_hit   = 1'b0;
        w_hit_f = '0;
        w_vic_f = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if ((CW'(i) < r_filled) && (r_frame_page[i] == r_page)) begin
                w_hit   = 1'b1;
                w_hit_f = IW'(i);
            end
            if ((CW'(i) < r_filled) && (CW'(r_rank[i]) == (r_filled - 1'b1))) begin
                w_vic_f = IW'(i);
            end
        end
    end

    // effective limit: zero acts as one, capped at the frame count
    assign w_lim8 = (r_frames_in_use == '0) ? 8'd1 : 8'(r_frames_in_use);
    assign w_fill = (8'(r_filled) < w_lim8) && (8'(r_filled) < 8'(FRAMES));

    // frame used and rank that moves to the front
    always_comb begin
        priority if (w_hit) begin
            w_f   = w_hit_f;
            w_old = CW'(r_rank[w_hit_f]);
        end else if (w_fill) begin
            w_f   = IW'(r_filled);
            w_old = r_filled;
        end else begin
            w_f   = w_vic_f;
            w_old = r_filled - 1'b1;
        end
    end

    // next tags, ranks and counters
    always_comb begin
        n_filled = r_filled;
        n_fault  = r_fault;
        for (int i = 0; i < FRAMES; i++) begin
            n_frame_page[i] = r_frame_page[i];
            n_rank[i]       = r_rank[i];
            if (i_cmd.execute) begin
                if ((CW'(i) < r_filled) && (CW'(r_rank[i]) < w_old)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
                if (IW'(i) == w_f) begin
                    n_rank[i] = '0;
                    if (!w_hit) begin
                        n_frame_page[i] = r_page;
                    end
                end
            end
        end
        if (i_cmd.execute && !w_hit) begin
            if (r_fault != '1) begin
                n_fault = r_fault + 1'b1;
            end
            if (w_fill) begin
                n_filled = r_filled + 1'b1;
            end
        end
    end

    // frame storage, no reset: entries are read only after being filled
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FRAMES; i++) begin
            r_frame_page[i] <= n_frame_page[i];
            r_rank[i]       <= n_rank[i];
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_fault  <= '0;
        end else begin
            r_filled <= n_filled;
            r_fault  <= n_fault;
        end
    end

    // result register
    assign w_f8   = 8'(w_f);
    assign w_ev64 = 64'(r_frame_page[w_vic_f]);
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out_hit   <= w_hit;
            r_out_frame <= w_f8[FRAME_IDX_W-1:0];
            r_out_ev    <= !w_hit && !w_fill;
            r_out_evp   <= (!w_hit && !w_fill) ? w_ev64[EVICT_PAGE_W-1:0] : '0;
        end
    end

    // hit, frame, evicted flag, evicted page, fault count, zero pad
    assign o_tdata = {3'b000, r_fault, r_out_evp, r_out_ev, r_out_frame, r_out_hit};

    // fill count never passes the frame count
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CW'(FRAMES))
        else $error("fill count overflow");

    // counters move only on execute
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.execute |=> ($stable(r_fault) && $stable(r_filled)))
        else $error("counters changed without a lookup");

    // a hit never counts as a fault
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && w_hit) |=> $stable(r_fault))
        else $error("fault counted on a hit");

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement_top.sv =====
// lru_page_replacement_top: stream wrapper of the lru page replacement block
// depends on lrupr_pkg, lrupr_ctrl and lrupr_datapath
`timescale 1ns / 1ps
`default_nettype none

// Each request on the slave stream is a page number; the block answers with one result per
// request telling whether the page was resident, the frame that holds it now, the page
// that was evicted (if any) and the saturating fault count. The page is registered first,
// then the parallel tag compare over the filled frames and the recency rank update of the
// frame array are done. The next request is taken as soon as that update is done, even
// while the result still waits in the output register; a result that is not taken holds
// the next lookup. frames_in_use is to be written through i_cfg_we and i_cfg_wdata only
// while the block is idle; the block does not enforce this. Zero acts as one and values
// above FRAMES act as FRAMES. Lowering it never empties frames that are already filled.
module lru_page_replacement_top
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // page_id [15:0]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // hit [0], frame_index [3:1], evicted_valid [4], evicted_page [20:5],
    // fault_total [52:21], zero [55:53]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata
);

    t_cmd w_cmd;

    // handshake controller
    lrupr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (w_cmd)
    );

    // frame array and counters
    lrupr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_page_id   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_tdata     (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench of the lru page replacement block
// depends on lrupr_pkg and lru_page_replacement_top from the rtl folder
`timescale 1ns / 1ps

module tb_top
    import lrupr_pkg::*;
();

    localparam int NUM_FRAMES     = 8;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_REQS     = 100;
    localparam int LONG_HOLD      = 250;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic                    hit;
        logic [FRAME_IDX_W-1:0]  frame;
        logic                    evicted;
        logic [EVICT_PAGE_W-1:0] evicted_page;
        logic [FAULT_W-1:0]      faults;
    } t_lookup_res;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REF,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [CFG_W-1:0]   limit;
        logic [PAGE_ID_W-1:0] page;
        t_lookup_res        res;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // page_id [15:0]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // hit [0], frame_index [3:1], evicted_valid [4], evicted_page [20:5],
    // fault_total [52:21], zero [55:53]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_W-1:0]       i_cfg_wdata;

    // page frame state mirrored by the predictor
    logic [PAGE_ID_W-1:0]   resident_pg [NUM_FRAMES];
    int unsigned            age_rank [NUM_FRAMES];
    int unsigned            frames_filled;
    logic [FAULT_W-1:0]     fault_cnt;
    logic [CFG_W-1:0]       limit_reg;

    t_lookup_res            expected_q [$];
    t_dir_row               dir_tab [$];
    int                     err_count = 0;
    int                     idle_cycles = 0;
    bit                     tx_mode;
    bit                     rx_mode;
    int                     rx_hold_req = 0;

    lru_page_replacement_top #(
        .FRAMES    (NUM_FRAMES),
        .PAGE_BITS (PAGE_ID_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mark frame f most recent, frames ahead of it age by one
    function automatic void move_to_front(input int unsigned f);
        int unsigned old_rank;
        old_rank = age_rank[f];
        for (int unsigned i = 0; i < frames_filled; i++) begin
            if (age_rank[i] < old_rank) age_rank[i]++;
        end
        age_rank[f] = 0;
    endfunction

    // lru lookup of one page reference, updates the mirrored state
    function automatic t_lookup_res lru_lookup(input logic [PAGE_ID_W-1:0] pg);
        t_lookup_res r;
        int unsigned lim;
        int unsigned f;
        int unsigned worst;
        bit found;
        r = '0;
        lim = limit_reg;
        if (lim == 0) lim = 1;
        if (lim > NUM_FRAMES) lim = NUM_FRAMES;
        found = 1'b0;
        f = 0;
        for (int unsigned i = 0; i < frames_filled; i++) begin
            if (!found && resident_pg[i] == pg) begin
                found = 1'b1;
                f = i;
            end
        end
        if (found) begin
            move_to_front(f);
        end else begin
            if (fault_cnt != '1) fault_cnt++;
            if (frames_filled < lim) begin
                // fill the next empty frame
                f = frames_filled;
                resident_pg[f] = pg;
                for (int unsigned i = 0; i < frames_filled; i++) age_rank[i]++;
                age_rank[f] = 0;
                frames_filled++;
            end else begin
                // replace the oldest page among all filled frames
                worst = 0;
                for (int unsigned i = 0; i < frames_filled; i++) begin
                    if (age_rank[i] > worst) begin
                        worst = age_rank[i];
                        f = i;
                    end
                end
                r.evicted = 1'b1;
                r.evicted_page = resident_pg[f];
                resident_pg[f] = pg;
                move_to_front(f);
            end
        end
        r.hit = found;
        r.frame = FRAME_IDX_W'(f);
        r.faults = fault_cnt;
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // directed table rows
    function automatic void add_cfg(input logic [CFG_W-1:0] v);
        t_dir_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.limit = v;
        dir_tab = {dir_tab, row};
    endfunction

    function automatic void add_ref(input logic [PAGE_ID_W-1:0] pg);
        t_dir_row row;
        row = '0;
        row.kind = ROW_REF;
        row.page = pg;
        dir_tab = {dir_tab, row};
    endfunction

    function automatic void add_known(input logic [PAGE_ID_W-1:0] pg, input logic h,
                                      input logic [FRAME_IDX_W-1:0] f, input logic ev,
                                      input logic [EVICT_PAGE_W-1:0] evp,
                                      input logic [FAULT_W-1:0] n);
        t_dir_row row;
        row = '0;
        row.kind = ROW_KNOWN;
        row.page = pg;
        row.res.hit = h;
        row.res.frame = f;
        row.res.evicted = ev;
        row.res.evicted_page = evp;
        row.res.faults = n;
        dir_tab = {dir_tab, row};
    endfunction

    task automatic log_mismatch(input string fld, input logic [FAULT_W-1:0] got,
                                input logic [FAULT_W-1:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, fld, got, want);
        err_count++;
    endtask

    // offer one page request, predict its result once accepted
    task automatic send_page(input logic [PAGE_ID_W-1:0] pg, input bit use_known,
                             input t_lookup_res known);
        int gap;
        t_lookup_res want;
        gap = pick_gap(tx_mode);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pg;
        do @(posedge i_clk); while (!s_axis_tready);
        want = lru_lookup(pg);
        if (use_known) want = known;
        expected_q = {expected_q, want};
    endtask

    // wait until every result is back
    task automatic drain_results();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // frames_in_use write while the block is idle
    task automatic write_limit(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        drain_results();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        limit_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // result receiver with random stalls and requested long holds
    initial begin
        int stall_left;
        int holds_seen;
        stall_left = 0;
        holds_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != holds_seen) begin
                holds_seen = rx_hold_req;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(rx_mode);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_lookup_res got;
        t_lookup_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit = m_axis_tdata[0];
            got.frame = m_axis_tdata[3:1];
            got.evicted = m_axis_tdata[4];
            got.evicted_page = m_axis_tdata[20:5];
            got.faults = m_axis_tdata[52:21];
            if (expected_q.size() == 0) begin
                log_mismatch("unexpected result", m_axis_tdata[52:21], '0);
            end else begin
                want = expected_q.pop_front();
                if (got.hit !== want.hit)
                    log_mismatch("hit", FAULT_W'(got.hit), FAULT_W'(want.hit));
                if (got.frame !== want.frame)
                    log_mismatch("frame_index", FAULT_W'(got.frame), FAULT_W'(want.frame));
                if (got.evicted !== want.evicted)
                    log_mismatch("evicted_valid", FAULT_W'(got.evicted),
                                 FAULT_W'(want.evicted));
                if (got.evicted_page !== want.evicted_page)
                    log_mismatch("evicted_page", FAULT_W'(got.evicted_page),
                                 FAULT_W'(want.evicted_page));
                if (got.faults !== want.faults)
                    log_mismatch("fault_total", got.faults, want.faults);
                if (m_axis_tdata[55:53] !== 3'b000)
                    log_mismatch("pad bits", FAULT_W'(m_axis_tdata[55:53]), '0);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lru_page_replacement_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        logic [PAGE_ID_W-1:0] pool [16];
        int pool_size;
        logic [PAGE_ID_W-1:0] pg;
        logic [CFG_W-1:0] lim;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        tx_mode = 1'b0;
        rx_mode = 1'b1;
        limit_reg = CFG_FRAMES_RESET;
        frames_filled = 0;
        fault_cnt = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            resident_pg[i] = '0;
            age_rank[i] = 0;
        end

        // limit zero acts as one, from empty: second fault replaces frame 0
        add_cfg(4'd0);
        add_known(16'h0000, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1);
        add_known(16'hFFFF, 1'b0, 3'd0, 1'b1, 16'h0000, 32'd2);
        add_known(16'hFFFF, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd2);
        // limit above frame count saturates, fill the rest in order
        add_cfg(4'd15);
        add_known(16'h0001, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd3);
        add_known(16'h0000, 1'b0, 3'd2, 1'b0, 16'h0000, 32'd4);
        add_known(16'h0002, 1'b0, 3'd3, 1'b0, 16'h0000, 32'd5);
        add_known(16'h8000, 1'b0, 3'd4, 1'b0, 16'h0000, 32'd6);
        add_known(16'h5555, 1'b0, 3'd5, 1'b0, 16'h0000, 32'd7);
        add_known(16'hAAAA, 1'b0, 3'd6, 1'b0, 16'h0000, 32'd8);
        add_known(16'h0004, 1'b0, 3'd7, 1'b0, 16'h0000, 32'd9);
        add_known(16'h0001, 1'b1, 3'd1, 1'b0, 16'h0000, 32'd9);
        // full: oldest page goes
        add_known(16'h1234, 1'b0, 3'd0, 1'b1, 16'hFFFF, 32'd10);
        // limit lowered after filling keeps every frame
        add_cfg(4'd2);
        add_known(16'h0002, 1'b1, 3'd3, 1'b0, 16'h0000, 32'd10);
        add_ref(16'h4321);
        add_cfg(4'd8);
        add_ref(16'h1234);
        add_ref(16'hFFFF);
        add_ref(16'h7FFF);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            case (dir_tab[k].kind)
                ROW_CFG:   write_limit(dir_tab[k].limit);
                ROW_KNOWN: send_page(dir_tab[k].page, 1'b1, dir_tab[k].res);
                default:   send_page(dir_tab[k].page, 1'b0, '0);
            endcase
        end

        // random phases over a small working set with some fresh pages
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: lim = 4'd8;
                1: lim = 4'd0;
                2: lim = 4'd15;
                3: lim = 4'd1;
                default: lim = CFG_W'($urandom_range(0, 15));
            endcase
            write_limit(lim);
            tx_mode = (ph % 4) != 0;
            rx_mode = (ph % 3) != 0;
            pool_size = (ph % 2) ? $urandom_range(6, 10) : $urandom_range(2, 16);
            for (int i = 0; i < pool_size; i++) pool[i] = PAGE_ID_W'($urandom);
            if (ph == 2) begin
                // hold results back so the block fills up and stalls requests
                tx_mode = 1'b0;
                rx_hold_req++;
            end
            for (int n = 0; n < PHASE_REQS; n++) begin
                if ($urandom_range(0, 99) < 85)
                    pg = pool[$urandom_range(0, pool_size - 1)];
                else
                    pg = PAGE_ID_W'($urandom);
                send_page(pg, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("lru_page_replacement_top verification clean");
        else
            $display("lru_page_replacement_top verification failed");
        $finish;
    end

endmodule
